>>> hdl/bounded_deque_with_dump_macros.svh
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_WITH_DUMP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_DUMP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bdq_pkg.sv
// Types and codes shared by the deque, its channels and its checker.
package bdq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatusW      = 2;

  // Command codes
  localparam logic [CmdW-1:0] CmdPushFront = 3'd0;
  localparam logic [CmdW-1:0] CmdPushBack  = 3'd1;
  localparam logic [CmdW-1:0] CmdPopFront  = 3'd2;
  localparam logic [CmdW-1:0] CmdPopBack   = 3'd3;
  localparam logic [CmdW-1:0] CmdDump      = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] StatOk    = 2'd0;
  localparam logic [StatusW-1:0] StatFull  = 2'd1;
  localparam logic [StatusW-1:0] StatEmpty = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_res;
    logic [StatusW-1:0]       status;
    logic                     last;
  } out_item_t;

endpackage

>>> hdl/bdq_chan_if.sv
// Valid/ready channel carrying one item of a chosen payload type.
interface bdq_chan_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> hdl/bdq_out_stage.sv
// Output register: holds one result item until the sink takes it.
module bdq_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bdq_pkg::out_item_t  item_i,
  output logic                free_o,
  bdq_chan_if.source          out_o
);

  logic               vld_q, vld_d;
  bdq_pkg::out_item_t data_q;

  // Register can take a new item when empty or being drained now
  assign free_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= item_i;
    end
  end

  assign out_o.valid   = vld_q;
  assign out_o.payload = data_q;

endmodule

>>> hdl/bounded_deque_with_dump.sv
// Bounded double-ended queue of 32-bit words with push/pop at both ends and a dump.
// The list lives in a DEPTH-entry ring memory with a registered read port,
// addressed through a front index and an entry count. A push (or any error result:
// full on push, empty on pop or dump) goes directly to the output register, so pushes
// stream at one item per cycle while it is free. A pop reads the word into
// the memory read register, then to the output register; no new item is taken before
// that. A dump streams one result per cycle while the sink is ready, with last set on
// the final entry; no new item is taken until it ends. Unused command codes (5 to 7)
// are consumed without any result. The memory powers up unwritten, needs no clearing.
module bounded_deque_with_dump #(
  parameter int unsigned DEPTH = bdq_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdq_chan_if.sink    in_i,
  bdq_chan_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  // Next ring index, wrapping at DEPTH
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  // Previous ring index, wrapping at zero
  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - IdxW'(1);
  endfunction

  // Ring slot at an offset from the front; the sum stays below twice DEPTH
  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] base,
                                              input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[IdxW-1:0];
  endfunction

  // Ring memory
  logic signed [bdq_pkg::ValueW-1:0] mem_q [DEPTH];
  logic signed [bdq_pkg::ValueW-1:0] rdata_q;
  logic                              we, re;
  logic [IdxW-1:0]                   waddr, raddr;
  logic signed [bdq_pkg::ValueW-1:0] wdata;

  // List pointers and dump sequencer
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;

  logic               busy, accept, is_empty, is_full, free;
  logic               load;
  bdq_pkg::out_item_t item;
  logic [bdq_pkg::CmdW-1:0] cmd;

  assign cmd      = in_i.payload.command;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == FullCnt);
  // Read data still to hand out, or dump reads still to issue
  assign busy     = pend_q || (rem_q != '0);
  assign in_i.ready = !busy && free;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    we          = 1'b0;
    waddr       = head_q;
    wdata       = in_i.payload.value;
    re          = 1'b0;
    raddr       = rd_ptr_q;
    load        = 1'b0;
    item.value_res = '0;
    item.status    = bdq_pkg::StatOk;
    item.last      = 1'b1;

    if (accept) begin
      unique case (cmd)
        bdq_pkg::CmdPushFront, bdq_pkg::CmdPushBack: begin
          load = 1'b1;
          if (is_full) begin
            item.status = bdq_pkg::StatFull;
          end else begin
            we = 1'b1;
            if (cmd == bdq_pkg::CmdPushFront) begin
              waddr  = idx_dec(head_q);
              head_d = idx_dec(head_q);
            end else begin
              waddr = slot_of(head_q, cnt_q);
            end
            cnt_d = cnt_q + OneCnt;
          end
        end
        bdq_pkg::CmdPopFront, bdq_pkg::CmdPopBack: begin
          if (is_empty) begin
            load        = 1'b1;
            item.status = bdq_pkg::StatEmpty;
          end else begin
            re          = 1'b1;
            pend_d      = 1'b1;
            pend_last_d = 1'b1;
            if (cmd == bdq_pkg::CmdPopFront) begin
              raddr  = head_q;
              head_d = idx_inc(head_q);
            end else begin
              raddr = slot_of(head_q, cnt_q - OneCnt);
            end
            cnt_d = cnt_q - OneCnt;
          end
        end
        bdq_pkg::CmdDump: begin
          if (is_empty) begin
            load        = 1'b1;
            item.status = bdq_pkg::StatEmpty;
          end else begin
            re          = 1'b1;
            raddr       = head_q;
            rd_ptr_d    = idx_inc(head_q);
            rem_d       = cnt_q - OneCnt;
            pend_d      = 1'b1;
            pend_last_d = (cnt_q == OneCnt);
          end
        end
        default: begin
        end
      endcase
    end else begin
      // Hand read data to the output register
      if (pend_q && free) begin
        load           = 1'b1;
        item.value_res = rdata_q;
        item.last      = pend_last_q;
        pend_d         = 1'b0;
      end
      // Issue the next dump read once the read register is free this edge
      if ((rem_q != '0) && (!pend_q || free)) begin
        re          = 1'b1;
        raddr       = rd_ptr_q;
        rd_ptr_d    = idx_inc(rd_ptr_q);
        rem_d       = rem_q - OneCnt;
        pend_d      = 1'b1;
        pend_last_d = (rem_q == OneCnt);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  bdq_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .item_i (item),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

>>> hdl/bdq_checker.sv
// Port-level checks for the deque, bound to the top level.
`include "bounded_deque_with_dump_macros.svh"

module bdq_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [bdq_pkg::CmdW-1:0] in_command_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     out_last_i
);

  logic push_acc, mid_dump_taken;

  assign push_acc = in_valid_i && in_ready_i &&
                    ((in_command_i == bdq_pkg::CmdPushFront) ||
                     (in_command_i == bdq_pkg::CmdPushBack));
  assign mid_dump_taken = out_valid_i && out_ready_i && !out_last_i;

  // A stalled result stays offered
  `BDQ_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // A push answers with a single final result on the next cycle
  `BDQ_ASSERT_NXT(a_push_result, push_acc, out_valid_i && out_last_i, "push result missing")

  // No new item while a dump is still streaming
  `BDQ_ASSERT_IMP(a_dump_blocks_in, out_valid_i && !out_last_i, !in_ready_i, "item taken mid dump")

  // A dump keeps streaming without gaps once the sink is ready
  `BDQ_ASSERT_NXT(a_dump_no_gap, mid_dump_taken, out_valid_i, "gap inside dump stream")

endmodule

bind bounded_deque_with_dump bdq_checker u_bdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.payload.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_last_i   (out_o.payload.last)
);

>>> dv/bdq_result_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded deque: tracks accepted commands, predicts each result and compares.
module bdq_result_checker
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  logic      cmd_ready_i,
  input  in_item_t  cmd_item_i,
  input  logic      res_valid_i,
  input  logic      res_ready_i,
  input  out_item_t res_item_i,
  output int        error_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        full_hits_o,
  output int        empty_hits_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Shadow copy of the list: ring of words, front index, entry count
  logic signed [ValueW-1:0] ring_words [DEPTH];
  logic [IdxW-1:0]          front_idx;
  logic [CntW-1:0]          entry_cnt;

  // Results still owed by the block, oldest first
  out_item_t owed_results [$];

  int errors;
  int checked;
  int full_hits;
  int empty_hits;

  function automatic logic [IdxW-1:0] ring_slot(int unsigned offset);
    return IdxW'((int'(front_idx) + offset) % DEPTH);
  endfunction

  // Update the shadow list for one command and queue the results it causes
  task automatic apply_command(in_item_t item);
    int unsigned n;
    logic signed [ValueW-1:0] word;
    case (item.command)
      CmdPushFront, CmdPushBack: begin
        if (entry_cnt == CntW'(DEPTH)) begin
          owed_results.push_back(out_item_t'{'0, StatFull, 1'b1});
        end else begin
          if (item.command == CmdPushFront) begin
            front_idx = (front_idx == '0) ? IdxW'(DEPTH - 1) : front_idx - IdxW'(1);
            ring_words[front_idx] = item.value;
          end else begin
            ring_words[ring_slot(32'(entry_cnt))] = item.value;
          end
          entry_cnt = entry_cnt + CntW'(1);
          owed_results.push_back(out_item_t'{'0, StatOk, 1'b1});
        end
      end
      CmdPopFront, CmdPopBack: begin
        if (entry_cnt == '0) begin
          owed_results.push_back(out_item_t'{'0, StatEmpty, 1'b1});
        end else begin
          if (item.command == CmdPopFront) begin
            word      = ring_words[front_idx];
            front_idx = ring_slot(1);
          end else begin
            word = ring_words[ring_slot(32'(entry_cnt - CntW'(1)))];
          end
          entry_cnt = entry_cnt - CntW'(1);
          owed_results.push_back(out_item_t'{word, StatOk, 1'b1});
        end
      end
      CmdDump: begin
        if (entry_cnt == '0) begin
          owed_results.push_back(out_item_t'{'0, StatEmpty, 1'b1});
        end else begin
          for (n = 0; n < 32'(entry_cnt); n++) begin
            owed_results.push_back(out_item_t'{ring_words[ring_slot(n)], StatOk,
                                               (n + 1 == 32'(entry_cnt))});
          end
        end
      end
      default: ; // unused codes leave the list alone and give nothing
    endcase
  endtask

  // Predict on accepted commands first, so a same-edge result still finds its entry
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      front_idx = '0;
      entry_cnt = '0;
      owed_results.delete();
      errors     = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
    end else begin
      if (cmd_valid_i && cmd_ready_i) begin
        apply_command(cmd_item_i);
      end
      if (res_valid_i && res_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: value_res %0d status %0d last %0d",
                 res_item_i.value_res, res_item_i.status, res_item_i.last);
          errors++;
        end else begin
          want = owed_results.pop_front();
          checked++;
          if (want.status == StatFull) full_hits++;
          if (want.status == StatEmpty) empty_hits++;
          if (res_item_i.value_res !== want.value_res) begin
            $error("value_res: expected %0d, got %0d", want.value_res, res_item_i.value_res);
            errors++;
          end
          if (res_item_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_item_i.status);
            errors++;
          end
          if (res_item_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_item_i.last);
            errors++;
          end
        end
      end
    end
    error_count_o <= errors;
    pending_o     <= owed_results.size();
    checked_o     <= checked;
    full_hits_o   <= full_hits;
    empty_hits_o  <= empty_hits;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the bounded deque: clock, reset, command and result pacing, verdict.
module tb;
  import bdq_pkg::*;

  localparam int unsigned Depth        = DefaultDepth;
  localparam int unsigned MaxGap       = 12;
  localparam int unsigned RandomCmds   = 440;
  localparam int unsigned PhaseLen     = 32;
  localparam int unsigned SettleCycles = 2 * Depth + 8;
  localparam int unsigned LongStall    = 80;
  localparam int unsigned CycleLimit   = 400000;

  localparam logic [CmdW-1:0] FirstUnusedCmd = CmdDump + CmdW'(1);
  localparam logic [CmdW-1:0] LastUnusedCmd  = '1;

  localparam logic signed [ValueW-1:0] MaxWord = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] MinWord = 32'sh8000_0000;

  // Mix of pushes and pops for one phase of the random part
  typedef enum int unsigned {MixFill, MixDrain, MixEven} cmd_mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bit hold_results = 1'b0;
  bit quiet_cmd    = 1'b0;
  bit quiet_res    = 1'b0;

  int cycle_count   = 0;
  int sent_count    = 0;
  int ignored_count = 0;
  int error_count;
  int pending_count;
  int checked_count;
  int full_hits;
  int empty_hits;

  bdq_chan_if #(.item_t(in_item_t))  cmd_if ();
  bdq_chan_if #(.item_t(out_item_t)) res_if ();

  bounded_deque_with_dump #(.DEPTH(Depth)) DUT (
    .clk_i,
    .rst_ni,
    .in_i  (cmd_if.sink),
    .out_o (res_if.source)
  );

  bdq_result_checker #(.DEPTH(Depth)) u_checker (
    .clk_i,
    .rst_ni,
    .cmd_valid_i   (cmd_if.valid),
    .cmd_ready_i   (cmd_if.ready),
    .cmd_item_i    (cmd_if.payload),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_item_i    (res_if.payload),
    .error_count_o (error_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count),
    .full_hits_o   (full_hits),
    .empty_hits_o  (empty_hits)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random stalls per item, one long stall on request
  initial begin
    int unsigned wait_cycles;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        wait_cycles  = LongStall;
      end else begin
        wait_cycles = quiet_res ? 0 : $urandom_range(0, MaxGap);
      end
      if (wait_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_cmd(input logic [CmdW-1:0] command, input logic signed [ValueW-1:0] value);
    int unsigned gap;
    gap = quiet_cmd ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= '{command: command, value: value};
    do @(posedge clk_i); while (!cmd_if.ready);
    sent_count++;
    if (command > CmdDump) ignored_count++;
  endtask

  // Stop offering until every owed result is back, then let the block settle
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly random words, now and then an extreme
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return MaxWord;
      1:       return MinWord;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CmdW-1:0] pick_command(cmd_mix_e mix);
    int unsigned roll;
    int unsigned push_share;
    roll = $urandom_range(0, 99);
    case (mix)
      MixFill:  push_share = 70;
      MixDrain: push_share = 25;
      default:  push_share = 47;
    endcase
    if (roll < 3) return CmdW'($urandom_range(32'(FirstUnusedCmd), 32'(LastUnusedCmd)));
    if (roll < 12) return CmdDump;
    if (roll < 12 + push_share) return $urandom_range(0, 1) ? CmdPushFront : CmdPushBack;
    return $urandom_range(0, 1) ? CmdPopFront : CmdPopBack;
  endfunction

  // Stimulus and verdict
  initial begin
    logic [CmdW-1:0] command;
    int unsigned     useful;
    cmd_mix_e        mix;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Errors on an empty list
    send_cmd(CmdPopFront, pick_value());
    send_cmd(CmdPopBack, pick_value());
    send_cmd(CmdDump, pick_value());
    // Extremes at both ends; push front from index zero wraps the ring
    send_cmd(CmdPushBack, MaxWord);
    send_cmd(CmdPushFront, MinWord);
    send_cmd(CmdPushBack, '0);
    send_cmd(CmdPushFront, '1);
    send_cmd(CmdDump, '0);
    send_cmd(CmdPopFront, '0);
    send_cmd(CmdPopBack, '0);
    send_cmd(CmdPopBack, '0);
    // Removing the single remaining entry, then popping the empty list
    send_cmd(CmdPopFront, '0);
    send_cmd(CmdPopFront, '0);
    send_cmd(CmdDump, '0);
    // Unused codes pass through without a result
    for (int c = 32'(FirstUnusedCmd); c <= 32'(LastUnusedCmd); c++) begin
      send_cmd(CmdW'(c), pick_value());
    end
    wait_idle();

    // Long result stall while pushes keep coming: list fills, pushes bounce, input backs up
    hold_results = 1'b1;
    quiet_cmd    = 1'b1;
    repeat (Depth + 6) begin
      send_cmd($urandom_range(0, 1) ? CmdPushFront : CmdPushBack, pick_value());
    end
    send_cmd(CmdDump, '0);
    quiet_cmd = 1'b0;
    wait_idle();

    // Random phases with changing push/pop balance and pacing
    useful = 0;
    while (useful < RandomCmds) begin
      mix       = cmd_mix_e'($urandom_range(0, 2));
      quiet_cmd = ($urandom_range(0, 3) == 0);
      quiet_res = ($urandom_range(0, 3) == 0);
      repeat (PhaseLen) begin
        command = pick_command(mix);
        send_cmd(command, pick_value());
        if (command <= CmdDump) useful++;
      end
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    quiet_cmd = 1'b0;
    quiet_res = 1'b0;
    wait_idle();

    $display("Run covered %0d commands (%0d with unused codes) and %0d checked results",
             sent_count, ignored_count, checked_count);
    $display("Rejected pushes on a full list: %0d, pops or dumps on an empty list: %0d",
             full_hits, empty_hits);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_chan_if.sv
hdl/bdq_out_stage.sv
hdl/bounded_deque_with_dump.sv
hdl/bdq_checker.sv
dv/bdq_result_checker.sv
dv/tb.sv
